/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] RESET_COLOR = 8'd2;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_MUL,
    S_ADD,
    S_RD_WAIT,
    S_COL_INC,
    S_ROW_INC,
    S_SHIFT,
    S_BLANK,
    S_DONE
  } state_t;

endpackage

/* src/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/tcw_addr_unit.sv */
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared adder with limit compare: pointer steps, cursor steps, linear index.
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
  parameter int W = 17
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] lim,
  output logic [W-1:0] sum,
  output logic         ge
);

  assign sum = a + b;
  assign ge  = (sum >= lim);

endmodule

/* src/text_console_cell_writer.sv */
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text screen store with cursor: put, set cursor, clear, read cell.
//
//  channel  | signals                                   | transfer
//  ---------+-------------------------------------------+-----------------------
//  request  | start, busy, req_type .. target_col       | start & !busy
//  config   | cfg_valid, cfg_ready, cfg_data            | cfg_valid & cfg_ready
//  result   | done, cursor_row_out .. scrolled          | done (one cycle)
//
// Every request passes through a shared adder under a sequencer, one step per
// cycle. After done the sequencer returns to idle. A scroll streams the store
// up one row, then blanks the last row. Clear and the pass after reset each
// write every cell once.
// busy is high during reset, during the reset pass and from acceptance through
// the done cycle. The result is shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_cell_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [7:0]  target_row,
  input  logic [7:0]  target_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [4:0]  cursor_row_out,
  output logic [6:0]  cursor_col_out,
  output logic [10:0] cursor_pos,
  output logic [15:0] cell_value,
  output logic        scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int UW    = AW + 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  state_t         state, state_next;
  req_t           req_q;
  logic [7:0]     ch_q;
  logic [7:0]     color_q;
  logic [RW-1:0]  tgt_row;
  logic [CW-1:0]  tgt_col;
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  cur_col;
  logic [7:0]     blank_attr;
  logic [7:0]     fill_color;
  logic           fill_report;
  logic           fin_q;
  logic [AW-1:0]  rp;
  logic [AW-1:0]  wp;
  logic           rd_more;
  logic           rd_pend;
  logic [AW-1:0]  mul_q;
  logic [15:0]    cell_q;
  logic           scr_q;

  logic [UW-1:0]  u_a, u_b, u_lim, u_sum;
  logic           u_ge;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [15:0]    ram_wdata, ram_rdata;
  logic           accept;
  logic           use_tgt;
  req_t           req_in;

  assign accept    = start && (state == S_IDLE);
  assign req_in    = req_t'(req_type);
  assign busy      = rst || (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign cfg_ready = !rst;
  assign scrolled  = scr_q;
  assign cell_value = cell_q;
  // first pass of a read addresses the target cell, every other pass the cursor
  assign use_tgt   = !fin_q && (req_q == REQ_READ);

  tcw_addr_unit #(.W(UW)) u_unit (
    .a   (u_a),
    .b   (u_b),
    .lim (u_lim),
    .sum (u_sum),
    .ge  (u_ge)
  );

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (u_ge) state_next = fill_report ? S_MUL : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (req_in)
            REQ_PUT: state_next = (char_code == CH_NEWLINE) ? S_ROW_INC : S_MUL;
            REQ_CLEAR: state_next = S_FILL;
            default: state_next = S_MUL;
          endcase
        end
      end
      S_MUL: state_next = S_ADD;
      S_ADD: begin
        if (fin_q) begin
          state_next = S_DONE;
        end else if (req_q == REQ_READ) begin
          state_next = S_RD_WAIT;
        end else begin
          state_next = S_COL_INC;
        end
      end
      S_RD_WAIT: state_next = S_MUL;
      S_COL_INC: state_next = u_ge ? S_ROW_INC : S_MUL;
      S_ROW_INC: state_next = u_ge ? S_SHIFT : S_MUL;
      S_SHIFT: begin
        if (!rd_more && !rd_pend) state_next = S_BLANK;
      end
      S_BLANK: begin
        if (u_ge) state_next = S_MUL;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit operands and RAM controls
  always_comb begin
    u_a       = '0;
    u_b       = UW'(1);
    u_lim     = UW'(CELLS);
    ram_we    = 1'b0;
    ram_waddr = rp;
    ram_wdata = {fill_color, CH_SPACE};
    ram_raddr = AW'(u_sum);
    case (state)
      S_FILL, S_BLANK: begin
        u_a    = UW'(rp);
        ram_we = 1'b1;
      end
      S_SHIFT: begin
        u_a       = UW'(rp);
        ram_raddr = rp;
        ram_we    = rd_pend;
        ram_waddr = wp;
        ram_wdata = ram_rdata;
      end
      S_ADD: begin
        u_a       = UW'(mul_q);
        u_b       = use_tgt ? UW'(tgt_col) : UW'(cur_col);
        ram_we    = !fin_q && (req_q == REQ_PUT);
        ram_waddr = AW'(u_sum);
        ram_wdata = {color_q, ch_q};
      end
      S_COL_INC: begin
        u_a   = UW'(cur_col);
        u_lim = UW'(COLUMNS);
      end
      S_ROW_INC: begin
        u_a   = UW'(cur_row);
        u_lim = UW'(ROWS);
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      rp            <= '0;
      fill_color    <= RESET_COLOR;
      blank_attr    <= RESET_COLOR;
      fill_report   <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      fin_q         <= 1'b0;
      rd_more       <= 1'b0;
      rd_pend       <= 1'b0;
      req_q         <= REQ_PUT;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        blank_attr <= cfg_data;
      end
      if (state_next == S_MUL && state != S_IDLE) begin
        fin_q <= 1'b1;
      end
      case (state)
        S_FILL: begin
          rp <= AW'(u_sum);
          if (u_ge) begin
            cur_row <= '0;
            cur_col <= '0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_q   <= req_in;
            ch_q    <= char_code;
            color_q <= color;
            tgt_row <= (target_row >= ROWS) ? RW'(ROWS - 1) : RW'(target_row);
            tgt_col <= (target_col >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(target_col);
            cell_q  <= '0;
            scr_q   <= 1'b0;
            fin_q   <= (req_in == REQ_SET) ||
                       (req_in == REQ_PUT && char_code == CH_RETURN);
            case (req_in)
              REQ_PUT: begin
                if (char_code == CH_NEWLINE || char_code == CH_RETURN) begin
                  cur_col <= '0;
                end
              end
              REQ_SET: begin
                cur_row <= (target_row >= ROWS) ? RW'(ROWS - 1) : RW'(target_row);
                cur_col <= (target_col >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(target_col);
              end
              REQ_CLEAR: begin
                rp          <= '0;
                fill_color  <= blank_attr;
                fill_report <= 1'b1;
              end
              default: begin
                fill_report <= fill_report;
              end
            endcase
          end
        end
        S_MUL: begin
          mul_q <= use_tgt ? AW'(tgt_row * COLUMNS) : AW'(cur_row * COLUMNS);
        end
        S_ADD: begin
          if (fin_q) begin
            cursor_row_out <= 5'(cur_row);
            cursor_col_out <= 7'(cur_col);
            cursor_pos     <= 11'(u_sum);
          end
        end
        S_RD_WAIT: begin
          cell_q <= ram_rdata;
        end
        S_COL_INC: begin
          cur_col <= u_ge ? '0 : CW'(u_sum);
        end
        S_ROW_INC: begin
          if (u_ge) begin
            scr_q      <= 1'b1;
            rp         <= AW'(COLUMNS);
            wp         <= '0;
            rd_more    <= (ROWS > 1);
            rd_pend    <= 1'b0;
            fill_color <= blank_attr;
          end else begin
            cur_row <= RW'(u_sum);
          end
        end
        S_SHIFT: begin
          if (rd_more) begin
            rp      <= AW'(u_sum);
            rd_more <= !u_ge;
          end
          rd_pend <= rd_more;
          if (rd_pend) begin
            wp <= wp + AW'(1);
          end
          if (!rd_more && !rd_pend) begin
            rp <= AW'((ROWS - 1) * COLUMNS);
          end
        end
        S_BLANK: begin
          rp <= AW'(u_sum);
          if (u_ge) begin
            cur_row <= RW'(ROWS - 1);
          end
        end
        default: begin
          rd_pend <= 1'b0;
        end
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request transfer did not raise busy");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur_row < ROWS && cur_col < COLUMNS))
    else $error("cursor outside the screen while idle");

  a_scroll_put: assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (req_q == REQ_PUT))
    else $error("scroll reported for a request other than put");

endmodule

/* test/tb_text_console_cell_writer.sv */
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer
// Self-checking bench for the text console cell writer. A short directed list
// covers reset contents, clamping, wrap, scroll and clear. Random requests
// follow under several default colors. A behavioral copy of screen and cursor
// predicts results the directed list leaves open; all are checked in order.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_COLS   = 80;
  localparam int SCR_ROWS   = 25;
  localparam int SCR_CELLS  = SCR_COLS * SCR_ROWS;
  localparam int PHASE_REQS = 265;

  typedef struct packed {
    req_t       kind;
    logic [7:0] ch;
    logic [7:0] color;
    logic [7:0] row;
    logic [7:0] col;
  } req_item_t;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] pos;
    logic [15:0] cell_val;
    logic        scr;
  } console_report_t;

  typedef struct packed {
    req_t        kind;
    logic [7:0]  ch;
    logic [7:0]  color;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        typed;
    logic [4:0]  w_row;
    logic [6:0]  w_col;
    logic [10:0] w_pos;
    logic [15:0] w_cell;
    logic        w_scr;
  } dir_row_t;

  // kind, char, color, row, col | typed, row, col, pos, cell, scrolled
  localparam dir_row_t DIRECTED_ROWS [24] = '{
    '{REQ_READ,  'h00,       'h00, 0,   0,   1, 0,  0,  0,    'h0220, 0},
    '{REQ_READ,  'hFF,       'hFF, 255, 255, 1, 0,  0,  0,    'h0220, 0},
    '{REQ_PUT,   'h41,       'h1F, 0,   0,   1, 0,  1,  1,    'h0000, 0},
    '{REQ_PUT,   'h00,       'h00, 255, 255, 0, 0,  0,  0,    'h0000, 0},
    '{REQ_PUT,   'hFF,       'hFF, 0,   0,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_READ,  'h00,       'h00, 0,   0,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_READ,  'h00,       'h00, 0,   2,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_PUT,   CH_RETURN,  'hAA, 7,   7,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_SET,   'h55,       'h55, 255, 255, 1, 24, 79, 1999, 'h0000, 0},
    '{REQ_PUT,   'h5A,       'h07, 0,   0,   1, 24, 0,  1920, 'h0000, 1},
    '{REQ_READ,  'h00,       'h00, 23,  79,  0, 0,  0,  0,    'h0000, 0},
    '{REQ_READ,  'h00,       'h00, 24,  79,  0, 0,  0,  0,    'h0000, 0},
    '{REQ_PUT,   CH_NEWLINE, 'h00, 0,   0,   1, 24, 0,  1920, 'h0000, 1},
    '{REQ_SET,   'h00,       'h00, 0,   79,  0, 0,  0,  0,    'h0000, 0},
    '{REQ_PUT,   'h71,       'h80, 0,   0,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_SET,   'h00,       'h00, 3,   200, 0, 0,  0,  0,    'h0000, 0},
    '{REQ_SET,   'h00,       'h00, 200, 3,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_PUT,   CH_RETURN,  'h00, 0,   0,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_READ,  'h00,       'h00, 255, 0,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_READ,  'h00,       'h00, 0,   255, 0, 0,  0,  0,    'h0000, 0},
    '{REQ_CLEAR, CH_NEWLINE, 'hC3, 9,   9,   1, 0,  0,  0,    'h0000, 0},
    '{REQ_READ,  'h00,       'h00, 24,  79,  1, 0,  0,  0,    'h0220, 0},
    '{REQ_PUT,   CH_NEWLINE, 'h00, 0,   0,   0, 0,  0,  0,    'h0000, 0},
    '{REQ_PUT,   CH_SPACE,   'h00, 0,   0,   0, 0,  0,  0,    'h0000, 0}
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [7:0]  char_code;
  logic [7:0]  color;
  logic [7:0]  target_row;
  logic [7:0]  target_col;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        done;
  logic [4:0]  cursor_row_out;
  logic [6:0]  cursor_col_out;
  logic [10:0] cursor_pos;
  logic [15:0] cell_value;
  logic        scrolled;

  logic [15:0]     shadow_screen [SCR_CELLS];
  int unsigned     shadow_row;
  int unsigned     shadow_col;
  logic [7:0]      blank_color;
  console_report_t owed_reports [$];
  int unsigned     mismatches;
  bit              quiet_stretch;

  text_console_cell_writer #(
    .COLUMNS(SCR_COLS),
    .ROWS   (SCR_ROWS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .char_code     (char_code),
    .color         (color),
    .target_row    (target_row),
    .target_col    (target_col),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .done          (done),
    .cursor_row_out(cursor_row_out),
    .cursor_col_out(cursor_col_out),
    .cursor_pos    (cursor_pos),
    .cell_value    (cell_value),
    .scrolled      (scrolled)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_to(input logic [7:0] v, input int unsigned lim);
    return (v >= lim) ? lim - 1 : int'(v);
  endfunction

  // Applies one request to the shadow screen and cursor.
  function automatic console_report_t console_step(input req_item_t it);
    console_report_t rep;
    int unsigned     spot;
    rep = '0;
    case (it.kind)
      REQ_PUT: begin
        if (it.ch == CH_NEWLINE) begin
          shadow_row++;
          shadow_col = 0;
        end else if (it.ch == CH_RETURN) begin
          shadow_col = 0;
        end else begin
          shadow_screen[shadow_row * SCR_COLS + shadow_col] = {it.color, it.ch};
          shadow_col++;
          if (shadow_col >= SCR_COLS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        if (shadow_row >= SCR_ROWS) begin
          for (int i = SCR_COLS; i < SCR_CELLS; i++)
            shadow_screen[i - SCR_COLS] = shadow_screen[i];
          for (int c = 0; c < SCR_COLS; c++)
            shadow_screen[(SCR_ROWS - 1) * SCR_COLS + c] = {blank_color, CH_SPACE};
          shadow_row--;
          rep.scr = 1'b1;
        end
      end
      REQ_SET: begin
        shadow_row = clamp_to(it.row, SCR_ROWS);
        shadow_col = clamp_to(it.col, SCR_COLS);
      end
      REQ_CLEAR: begin
        foreach (shadow_screen[i]) shadow_screen[i] = {blank_color, CH_SPACE};
        shadow_row = 0;
        shadow_col = 0;
      end
      default: begin
        spot = clamp_to(it.row, SCR_ROWS) * SCR_COLS + clamp_to(it.col, SCR_COLS);
        rep.cell_val = shadow_screen[spot];
      end
    endcase
    rep.row = shadow_row[4:0];
    rep.col = shadow_col[6:0];
    rep.pos = 11'(shadow_row * SCR_COLS + shadow_col);
    return rep;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 39) == 0) quiet_stretch = !quiet_stretch;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_target(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'(lim - 1);
    if (r < 7) return 8'($urandom_range(0, lim - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic req_item_t random_request();
    req_item_t   it;
    int unsigned r;
    it.ch    = 8'($urandom_range(0, 255));
    it.color = 8'($urandom_range(0, 255));
    it.row   = pick_target(SCR_ROWS);
    it.col   = pick_target(SCR_COLS);
    r = $urandom_range(0, 99);
    if (r < 58) begin
      it.kind = REQ_PUT;
    end else if (r < 66) begin
      it.kind = REQ_PUT;
      it.ch   = CH_NEWLINE;
    end else if (r < 70) begin
      it.kind = REQ_PUT;
      it.ch   = CH_RETURN;
    end else if (r < 82) begin
      it.kind = REQ_SET;
    end else if (r < 99) begin
      it.kind = REQ_READ;
    end else begin
      it.kind = REQ_CLEAR;
    end
    return it;
  endfunction

  // Drives one request and returns at the edge where it transfers.
  task automatic send_request(input req_item_t it, input bit typed,
                              input console_report_t want);
    int unsigned     gap;
    console_report_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= it.kind;
    char_code  <= it.ch;
    color      <= it.color;
    target_row <= it.row;
    target_col <= it.col;
    do @(posedge clk); while (busy !== 1'b0);
    rep = console_step(it);
    owed_reports.push_back(typed ? want : rep);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (owed_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_default_color(input logic [7:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    blank_color = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    console_report_t want;
    if (!rst && done === 1'b1) begin
      if (owed_reports.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = owed_reports.pop_front();
        check_field("cursor_row_out", 32'(want.row), 32'(cursor_row_out));
        check_field("cursor_col_out", 32'(want.col), 32'(cursor_col_out));
        check_field("cursor_pos", 32'(want.pos), 32'(cursor_pos));
        check_field("cell_value", 32'(want.cell_val), 32'(cell_value));
        check_field("scrolled", 32'(want.scr), 32'(scrolled));
      end
    end
  end

  initial begin
    #40_000_000;
    $display("text_console_cell_writer verification failed");
    $finish;
  end

  initial begin
    logic [7:0]      phase_colors [5];
    req_item_t       it;
    console_report_t want;
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    req_type   = REQ_PUT;
    char_code  = '0;
    color      = '0;
    target_row = '0;
    target_col = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    mismatches = 0;
    quiet_stretch = 1'b0;
    shadow_row  = 0;
    shadow_col  = 0;
    blank_color = RESET_COLOR;
    foreach (shadow_screen[i]) shadow_screen[i] = {RESET_COLOR, CH_SPACE};
    phase_colors = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h5A,
                     8'($urandom_range(0, 255))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      it   = '{DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].color,
               DIRECTED_ROWS[i].row, DIRECTED_ROWS[i].col};
      want = '{DIRECTED_ROWS[i].w_row, DIRECTED_ROWS[i].w_col, DIRECTED_ROWS[i].w_pos,
               DIRECTED_ROWS[i].w_cell, DIRECTED_ROWS[i].w_scr};
      send_request(it, DIRECTED_ROWS[i].typed, want);
    end

    foreach (phase_colors[p]) begin
      write_default_color(phase_colors[p]);
      it = random_request();
      it.kind = REQ_CLEAR;
      send_request(it, 1'b0, '0);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) drain_results();
        send_request(random_request(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && owed_reports.size() == 0) begin
      $display("text_console_cell_writer verification clean");
    end else begin
      $display("text_console_cell_writer verification failed");
    end
    $finish;
  end

endmodule
